// File: rtl/core/btds_pkg.sv
// Package for the byte translate / delete / squeeze filter.
// Holds the table entry type, command codes and register indexes.
// No dependencies.
package btds_pkg;

	// Request kinds carried on s_tuser
	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_DATA = 1'b1
	} cmd_t;

	// Configuration register indexes
	typedef enum logic {
		REG_DELETE_MODE  = 1'b0,
		REG_SQUEEZE_MODE = 1'b1
	} reg_index_t;

	// One table entry: replacement byte and the two marks
	typedef struct packed {
		logic [7:0] target;
		logic       del;
		logic       sq;
	} tbl_entry_t;

	localparam int unsigned S_TDATA_W = 32;
	localparam int unsigned M_TDATA_W = 8;

endpackage : btds_pkg

// File: rtl/core/byte_translate_delete_squeeze.sv
// Byte translate / delete / squeeze stream filter, top level.
// Depends on btds_pkg and btds_table.
//
// The block filters a byte stream through a 256-entry character table held
// in one synchronous memory. A load request (s_tuser = 0) writes one entry
// (replacement byte, delete mark, squeeze mark) in the cycle it is accepted
// and gives no output. A data request (s_tuser = 1) is filtered: in delete
// mode a delete-marked byte is dropped and other bytes pass unchanged,
// otherwise the byte is replaced by its entry; in squeeze mode a
// squeeze-marked byte equal to the last kept marked byte is dropped, and
// any unmarked kept byte clears that memory. One request is accepted per
// cycle, loads and data alike, as long as the output is taken; a kept byte
// passes through stage 1, stage 2 and the output register before it
// appears on m_tdata. Two dependent table reads set this depth: the entry
// of the input byte, then the squeeze mark of its replacement, each through
// a registered read port. The table is not cleared at reset: load every
// entry that the data can reach before sending data. Load and data requests
// may be mixed freely; a load takes effect for every data request accepted
// after it. Write the mode registers only while the filter is empty.
module byte_translate_delete_squeeze #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port
	input  logic                               cfg_we,
	input  btds_pkg::reg_index_t               cfg_index,
	input  logic                               cfg_data,
	// Request stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// s_tdata, lowest bit up: entry_index[7:0], entry_target[15:8],
	// entry_delete[16], entry_squeeze[17], data_byte[25:18], zero pad[31:26]
	input  logic [btds_pkg::S_TDATA_W-1:0]     s_tdata,
	// s_tuser: command (0 load entry, 1 data byte)
	input  btds_pkg::cmd_t                     s_tuser,
	// Result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// m_tdata, lowest bit up: out_byte[7:0]
	output logic [btds_pkg::M_TDATA_W-1:0]     m_tdata
);
	import btds_pkg::*;

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

	// Request fields
	logic [7:0] entry_index;
	logic [7:0] entry_target;
	logic       entry_delete;
	logic       entry_squeeze;
	logic [7:0] data_byte;

	assign entry_index   = s_tdata[7:0];
	assign entry_target  = s_tdata[15:8];
	assign entry_delete  = s_tdata[16];
	assign entry_squeeze = s_tdata[17];
	assign data_byte     = s_tdata[25:18];

	// Mode registers
	logic delete_mode_q;
	logic squeeze_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delete_mode_q  <= 1'b0;
			squeeze_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DELETE_MODE:  delete_mode_q  <= cfg_data;
				REG_SQUEEZE_MODE: squeeze_mode_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Whole pipeline advances together; it stalls only when a result is
	// waiting at the output and the sink does not take it.
	logic out_valid_q;
	logic advance;
	logic accept;
	logic load_req;
	logic data_req;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = advance;
	assign accept   = s_tvalid && s_tready;
	assign load_req = accept && (s_tuser == CMD_LOAD);
	assign data_req = accept && (s_tuser == CMD_DATA);

	// Table memory
	tbl_entry_t wr_entry;
	tbl_entry_t rd1_entry;
	tbl_entry_t rd2_entry;

	assign wr_entry = '{target: entry_target, del: entry_delete, sq: entry_squeeze};

	// Stage 1: entry of the input byte is being read
	logic       valid_s1;
	logic [7:0] byte_s1;

	btds_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk      (clk),
		.wr_en    (load_req),
		.wr_addr  (entry_index[IDX_W-1:0]),
		.wr_entry (wr_entry),
		.rd_en    (advance),
		.rd1_addr (data_byte[IDX_W-1:0]),
		.rd2_addr (rd1_entry.target[IDX_W-1:0]),
		.rd1_entry(rd1_entry),
		.rd2_entry(rd2_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= data_req;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_s1 <= data_byte;
		end
	end

	// Stage 2: delete step done, squeeze mark of the replacement being read.
	// In delete mode the byte is unchanged, so its own mark is already known.
	logic       valid_s2;
	logic [7:0] byte_s2;
	logic       own_sq_s2;
	logic       translate_s2;
	logic       keep_s1;

	assign keep_s1 = valid_s1 && !(delete_mode_q && rd1_entry.del);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= keep_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_s2      <= delete_mode_q ? byte_s1 : rd1_entry.target;
			own_sq_s2    <= rd1_entry.sq;
			translate_s2 <= !delete_mode_q;
		end
	end

	// Squeeze step and output register
	logic       have_prev_q;
	logic [7:0] prev_byte_q;
	logic [7:0] out_byte_q;
	logic       sq_s2;
	logic       squeeze_hit;
	logic       drop_s2;

	assign sq_s2       = translate_s2 ? rd2_entry.sq : own_sq_s2;
	assign squeeze_hit = squeeze_mode_q && sq_s2;
	assign drop_s2     = squeeze_hit && have_prev_q && (prev_byte_q == byte_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			have_prev_q <= 1'b0;
			prev_byte_q <= 8'd0;
		end else if (advance) begin
			out_valid_q <= valid_s2 && !drop_s2;
			// Update the squeeze memory for each byte that survives
			if (valid_s2 && !drop_s2) begin
				have_prev_q <= squeeze_hit;
				if (squeeze_hit) begin
					prev_byte_q <= byte_s2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= byte_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;

endmodule : byte_translate_delete_squeeze

// File: rtl/core/btds_table.sv
// Character table of the filter: one write port, two registered read ports.
// Depends on btds_pkg for the entry type.
module btds_table #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
	input  btds_pkg::tbl_entry_t           wr_entry,
	input  logic                           rd_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd1_addr,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd2_addr,
	output btds_pkg::tbl_entry_t           rd1_entry,
	output btds_pkg::tbl_entry_t           rd2_entry
);
	import btds_pkg::*;

	tbl_entry_t mem_q [TABLE_DEPTH];
	tbl_entry_t rd1_q;
	tbl_entry_t rd2_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
	end

	// Hold read data while the pipeline is stalled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd1_q <= mem_q[rd1_addr];
			rd2_q <= mem_q[rd2_addr];
		end
	end

	assign rd1_entry = rd1_q;
	assign rd2_entry = rd2_q;

endmodule : btds_table

// File: test/tb.sv
// Self-checking bench for byte_translate_delete_squeeze: loads the whole table, then
// drives directed and random byte runs under all mode settings and predicts every kept byte.
// Depends on btds_pkg and the filter RTL only.
`timescale 1ns / 100ps

module tb;
	import btds_pkg::*;

	localparam int QUIET_CYCLES = 8;     // settling time after a drain, in cycles
	localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	reg_index_t           cfg_index = REG_DELETE_MODE;
	logic                 cfg_data  = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	// s_tdata, lowest bit up: entry_index, entry_target, entry_delete, entry_squeeze,
	// data_byte, zero pad
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	// s_tuser: command
	cmd_t                 s_tuser   = CMD_LOAD;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	// m_tdata, lowest bit up: out_byte
	logic [M_TDATA_W-1:0] m_tdata;

	// Own copy of the filter state, advanced at each accepted request
	logic [7:0] map_target [256];
	logic       map_delete [256];
	logic       map_squeeze[256];
	logic       del_mode   = 1'b0;
	logic       sq_mode    = 1'b0;
	logic       have_prev  = 1'b0;
	logic [7:0] prev_kept  = 8'h00;

	logic [7:0] kept_bytes[$];  // bytes still owed by the filter, oldest first

	bit no_gaps      = 1'b0;
	int err_count    = 0;
	int n_requests   = 0;
	int n_loads      = 0;
	int n_checked    = 0;
	int n_dropped    = 0;
	int stall_cycles = 0;

	byte_translate_delete_squeeze u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// Work out what one data byte turns into, and queue it if the filter keeps it
	task automatic filter_byte(input logic [7:0] in_byte);
		logic [7:0] b;
		b = in_byte;
		if (del_mode) begin
			// deleted bytes vanish without touching the squeeze memory
			if (map_delete[b]) begin
				n_dropped++;
				return;
			end
		end else begin
			b = map_target[b];
		end
		if (sq_mode && map_squeeze[b]) begin
			if (have_prev && prev_kept == b) begin
				n_dropped++;
				return;
			end
			have_prev = 1'b1;
			prev_kept = b;
		end else begin
			// any unmarked kept byte, or squeeze off, forgets the run
			have_prev = 1'b0;
		end
		kept_bytes.push_back(b);
	endtask

	// Predict and check at every edge; all values sampled here are the pre-edge ones.
	// Results seen at an edge belong to earlier requests, so check before predicting.
	always @(posedge clk) begin
		m_tready <= no_gaps || ($urandom_range(99) >= 31);
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (kept_bytes.size() == 0) begin
					$error("out_byte: expected none, got %02h", m_tdata);
					err_count++;
				end else begin
					if (m_tdata !== kept_bytes[0]) begin
						$error("out_byte: expected %02h, got %02h", kept_bytes[0], m_tdata);
						err_count++;
					end
					void'(kept_bytes.pop_front());
					n_checked++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_DELETE_MODE:  del_mode = cfg_data;
					REG_SQUEEZE_MODE: sq_mode  = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				n_requests++;
				if (s_tuser == CMD_LOAD) begin
					// a load only writes the entry; the squeeze memory is left alone
					map_target [s_tdata[7:0]] = s_tdata[15:8];
					map_delete [s_tdata[7:0]] = s_tdata[16];
					map_squeeze[s_tdata[7:0]] = s_tdata[17];
					n_loads++;
				end else begin
					filter_byte(s_tdata[25:18]);
				end
			end
		end
	end

	// Drop the run if nothing at all is handed over for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Offer one request and hold it until it is taken; valid stays high afterwards
	task automatic send_request(input cmd_t cmd, input logic [7:0] idx, input logic [7:0] tgt,
			input logic del, input logic sq, input logic [7:0] dbyte);
		while (!no_gaps && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {6'b0, dbyte, sq, del, tgt, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic load_entry(input logic [7:0] idx, input logic [7:0] tgt,
			input logic del, input logic sq);
		// data_byte carries noise on loads; the filter must ignore it
		send_request(CMD_LOAD, idx, tgt, del, sq, 8'($urandom));
	endtask

	task automatic send_byte(input logic [7:0] b);
		// entry fields carry noise on data requests
		send_request(CMD_DATA, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), b);
	endtask

	// Hold the sender until every owed byte has come out, then let the pipe settle
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (kept_bytes.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_index_t idx, input logic value);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Every entry must be written before data may read it
	task automatic test_table_load;
		for (int i = 0; i < 256; i++) begin
			load_entry(8'(i), 8'($urandom), 1'($urandom), 1'($urandom));
		end
		// a few known entries for the directed cases
		load_entry(8'h41, 8'h41, 1'b0, 1'b1);  // marked, maps to itself
		load_entry(8'h42, 8'h41, 1'b0, 1'b0);  // folds onto the marked byte
		load_entry(8'h00, 8'hFF, 1'b1, 1'b1);  // deleted, marked
		load_entry(8'hFF, 8'h00, 1'b0, 1'b1);  // marked, maps to bottom value
		load_entry(8'h10, 8'h10, 1'b0, 1'b0);  // unmarked, maps to itself
	endtask

	task automatic test_translate;
		cfg_write(REG_DELETE_MODE, 1'b0);
		cfg_write(REG_SQUEEZE_MODE, 1'b0);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h41);
		send_byte(8'h42);
		send_byte(8'h41);
	endtask

	task automatic test_delete;
		cfg_write(REG_DELETE_MODE, 1'b1);
		send_byte(8'h00);
		send_byte(8'h41);
		send_byte(8'hFF);
		send_byte(8'h10);
	endtask

	task automatic test_squeeze;
		cfg_write(REG_DELETE_MODE, 1'b0);
		cfg_write(REG_SQUEEZE_MODE, 1'b1);
		send_byte(8'h41);
		send_byte(8'h41);
		send_byte(8'h42);
		// a load between run members must not break the run
		load_entry(8'h55, 8'h55, 1'b0, 1'b0);
		send_byte(8'h41);
		send_byte(8'h10);
		send_byte(8'h41);
		// a register write must not break the run either
		cfg_write(REG_DELETE_MODE, 1'b0);
		send_byte(8'h41);
		send_byte(8'hFF);
		send_byte(8'hFF);
	endtask

	task automatic test_delete_squeeze;
		cfg_write(REG_DELETE_MODE, 1'b1);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		// squeeze off forgets the run, so the byte is kept once squeeze is back on
		cfg_write(REG_SQUEEZE_MODE, 1'b0);
		send_byte(8'hFF);
		cfg_write(REG_SQUEEZE_MODE, 1'b1);
		send_byte(8'hFF);
	endtask

	// Mostly runs of one byte with random content, plus table reloads and noise bytes
	task automatic test_random_stream;
		int sent;
		int pick;
		int run_len;
		logic [7:0] run_byte;
		for (int phase = 0; phase < 8; phase++) begin
			cfg_write(REG_DELETE_MODE, phase[0]);
			cfg_write(REG_SQUEEZE_MODE, phase[1]);
			no_gaps = (phase == 5);
			sent = 0;
			while (sent < 90) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					load_entry(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
					sent++;
				end else if (pick < 20) begin
					send_byte(8'($urandom));
					sent++;
				end else begin
					// favour low values so runs recur across the stream
					run_byte = ($urandom_range(1) == 0) ? 8'($urandom_range(15)) : 8'($urandom);
					run_len  = $urandom_range(6, 1);
					repeat (run_len) begin
						send_byte(($urandom_range(99) < 85) ? run_byte : 8'($urandom));
						sent++;
					end
				end
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_load();
		test_translate();
		test_delete();
		test_squeeze();
		test_delete_squeeze();
		test_random_stream();

		drain();
		if (kept_bytes.size() != 0) begin
			$error("out_byte: %0d expected bytes never arrived", kept_bytes.size());
			err_count++;
		end

		$display("tb: %0d requests (%0d table loads) under all four mode settings",
			n_requests, n_loads);
		$display("tb: %0d kept bytes compared, %0d bytes dropped by the filter",
			n_checked, n_dropped);
		if (err_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/btds_pkg.sv
rtl/core/btds_table.sv
rtl/core/byte_translate_delete_squeeze.sv
test/tb.sv
